[rtl/tccw_pkg.sv]
package tccw_pkg;

	// console geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;

	localparam logic [ADDR_W-1:0] TEXT_START = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ROW   = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

	// item kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// control characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BLANK = 8'h20;

	localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

	// register indexes
	localparam logic REG_TAB  = 1'b0;
	localparam logic REG_FILL = 1'b1;

	// fill value selects
	localparam logic [1:0] FILL_RESET  = 2'd0;
	localparam logic [1:0] FILL_ATTR   = 2'd1;
	localparam logic [1:0] FILL_SCROLL = 2'd2;

	// address load selects
	localparam logic [1:0] ADDR_TEXT = 2'd0;
	localparam logic [1:0] ADDR_LAST = 2'd1;

	typedef struct packed {
		logic       load_item;
		logic       exec_put;
		logic       exec_clear;
		logic       rd_cell;
		logic       copy_step;
		logic       fill_step;
		logic [1:0] fill_sel;
		logic       addr_load;
		logic [1:0] addr_sel;
		logic       load_result;
	} tccw_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       need_scroll;
		logic       addr_last;
		logic       copy_last;
		logic       out_free;
	} tccw_status_t;

endpackage

[rtl/tccw_ctrl.sv]
module tccw_ctrl
	import tccw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  tccw_status_t status,
	output tccw_cmd_t    cmd
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_COPY   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_FILL   = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		case (state_q)
			S_INIT: begin
				cmd.fill_step = 1'b1;
				cmd.fill_sel  = FILL_RESET;
				if (status.addr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_n       = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.kind)
					KIND_PUT: begin
						cmd.exec_put = 1'b1;
						if (status.need_scroll) begin
							cmd.addr_load = 1'b1;
							cmd.addr_sel  = ADDR_TEXT;
							state_n       = S_COPY;
						end else begin
							state_n = S_DONE;
						end
					end
					KIND_CLEAR: begin
						cmd.exec_clear = 1'b1;
						cmd.addr_load  = 1'b1;
						cmd.addr_sel   = ADDR_TEXT;
						state_n        = S_CLEAR;
					end
					KIND_READ: begin
						cmd.rd_cell = 1'b1;
						state_n     = S_DONE;
					end
					default: state_n = S_DONE;
				endcase
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (status.copy_last) state_n = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.addr_load = 1'b1;
				cmd.addr_sel  = ADDR_LAST;
				state_n       = S_FILL;
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				cmd.fill_sel  = FILL_SCROLL;
				if (status.addr_last) state_n = S_DONE;
			end
			S_CLEAR: begin
				cmd.fill_step = 1'b1;
				cmd.fill_sel  = FILL_ATTR;
				if (status.addr_last) state_n = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_result = 1'b1;
					state_n         = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_n;
	end

endmodule

[rtl/tccw_dp.sv]
module tccw_dp
	import tccw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [31:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	input  tccw_cmd_t    cmd,
	output tccw_status_t status
);

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_q;

	logic [1:0]        kind_q;
	logic [7:0]        ch_q;
	logic [7:0]        attr_q;
	logic [10:0]       idx_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [4:0]        tab_q;
	logic [7:0]        fill_attr_q;
	logic              scrolled_q;

	logic [ADDR_W-1:0] addr_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] copy_addr_s1;

	logic              out_valid_q;
	logic [CELL_W-1:0] res_data_q;
	logic [COL_W-1:0]  res_col_q;
	logic [ROW_W-1:0]  res_row_q;
	logic              res_scrolled_q;

	logic [7:0]        col_n;
	logic [ROW_W-1:0]  row_n;
	logic [COL_W-1:0]  wcol;
	logic              put_we;
	logic [7:0]        put_ch;
	logic              need_scroll;
	logic [ADDR_W-1:0] put_addr;
	logic              idx_ok;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] fill_val;

	// cursor step for a put item
	always_comb begin
		col_n  = {1'b0, col_q};
		row_n  = row_q;
		wcol   = col_q;
		put_we = 1'b0;
		put_ch = ch_q;
		case (ch_q)
			CH_LF: begin
				col_n = '0;
				row_n = row_q + 1'b1;
			end
			CH_CR: col_n = '0;
			CH_BS: begin
				wcol   = (col_q != '0) ? col_q - 1'b1 : col_q;
				col_n  = {1'b0, wcol};
				put_we = 1'b1;
				put_ch = CH_BLANK;
			end
			CH_TAB: col_n = {1'b0, col_q} + {3'b0, tab_q};
			default: begin
				put_we = 1'b1;
				col_n  = {1'b0, col_q} + 8'd1;
			end
		endcase
		if (col_n >= 8'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
		need_scroll = (row_n >= ROW_W'(ROWS));
	end

	assign put_addr = ADDR_W'(row_q * COLUMNS) + ADDR_W'(wcol);
	assign idx_ok   = (idx_q < 11'(CELLS));

	always_comb begin
		case (cmd.fill_sel)
			FILL_ATTR:   fill_val = {attr_q, CH_BLANK};
			FILL_SCROLL: fill_val = {fill_attr_q, CH_BLANK};
			default:     fill_val = RESET_CELL;
		endcase
	end

	// single write port: copy write-back, sweep fill or cursor cell
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = fill_val;
		if (copy_v_s1) begin
			we    = 1'b1;
			waddr = copy_addr_s1;
			wdata = rd_q;
		end else if (cmd.fill_step) begin
			we = 1'b1;
		end else if (cmd.exec_put && put_we) begin
			we    = 1'b1;
			waddr = put_addr;
			wdata = {attr_q, put_ch};
		end
	end

	assign re    = cmd.copy_step | (cmd.rd_cell & idx_ok);
	assign raddr = cmd.copy_step ? ADDR_W'(addr_q + TEXT_START) : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= s_tuser;
			ch_q   <= s_tdata[7:0];
			attr_q <= s_tdata[15:8];
			idx_q  <= s_tdata[26:16];
		end
		if (cmd.copy_step) copy_addr_s1 <= addr_q;
		if (cmd.load_result) begin
			res_data_q     <= (kind_q == KIND_READ && idx_ok) ? rd_q : '0;
			res_col_q      <= col_q;
			res_row_q      <= row_q;
			res_scrolled_q <= scrolled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			tab_q       <= 5'd5;
			fill_attr_q <= 8'd7;
			scrolled_q  <= 1'b0;
			addr_q      <= '0;
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TAB:  tab_q       <= cfg_data[4:0];
					REG_FILL: fill_attr_q <= cfg_data;
					default:  ;
				endcase
			end
			if (cmd.load_item) scrolled_q <= 1'b0;
			if (cmd.exec_put) begin
				col_q      <= col_n[COL_W-1:0];
				row_q      <= need_scroll ? ROW_W'(ROWS - 1) : row_n;
				scrolled_q <= need_scroll;
			end
			if (cmd.exec_clear) begin
				col_q <= '0;
				row_q <= ROW_W'(1);
			end
			if (cmd.addr_load) addr_q <= (cmd.addr_sel == ADDR_LAST) ? LAST_ROW : TEXT_START;
			else if (cmd.copy_step || cmd.fill_step) begin
				if (addr_q != CELL_LAST) addr_q <= addr_q + 1'b1;
			end
			copy_v_s1 <= cmd.copy_step;
			if (cmd.load_result) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign status.kind        = kind_q;
	assign status.need_scroll = need_scroll;
	assign status.addr_last   = (addr_q == CELL_LAST);
	assign status.copy_last   = (addr_q == COPY_LAST);
	assign status.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b0, res_scrolled_q, res_row_q, res_col_q, res_data_q};

endmodule

[rtl/text_console_cell_writer_core.sv]
// text console over an 80x25 store of 16-bit cells (attribute byte above character byte),
// row 0 kept as a status row. each input transfer is one item: a put (printable character
// or a newline, return, backspace or tab code), a clear of rows 1 to 24, or a read of one
// cell; every item gives exactly one result transfer with the cell read (zero unless a
// read), the cursor after the item and a scrolled flag. a plain put or a read goes from
// the item register through the decode and done states to the result register; the cell
// memory has a single write port and a registered read. a put that moves below row 24
// scrolls: rows are copied up one cell per cycle (1840 cells, then a drain state) and the
// bottom row of 80 cells is filled. a clear fills 1920 cells, one per cycle. after reset a
// clearing pass writes blank cells 0x0720 into all 2000 cells with no input taken;
// configuration writes are taken at any time.
module text_console_cell_writer_core
	import tccw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_data[15:0], cursor_col[22:16], cursor_row[27:23],
	                               // scrolled[28]
	// configuration writes: 0 tab_advance, 1 scroll_fill_attr
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// command and status between sequencer and datapath
	tccw_cmd_t    cmd;
	tccw_status_t status;

	// sequencer: init fill, item decode, scroll copy and fill sweeps, result handoff
	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: cell memory, cursor, registers and the output register
	tccw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
